### src/pfde_pkg.sv
package pfde_pkg;

    localparam int SIDE  = 5;
    localparam int CELLS = 25;
    localparam int ALPHA = 26;

    localparam logic [4:0] LET_I = 5'd8;
    localparam logic [4:0] LET_J = 5'd9;
    localparam logic [4:0] LET_Q = 5'd16;
    localparam logic [4:0] LET_X = 5'd23;

    // input word kinds
    localparam logic [1:0] ACT_NEW_KEY = 2'd0;
    localparam logic [1:0] ACT_KEY     = 2'd1;
    localparam logic [1:0] ACT_MSG     = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    // queued commands
    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_KEY      = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;
    localparam logic [1:0] OP_PAIR     = 2'd3;

    localparam int DEF_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0] op;
        logic [4:0] a;
        logic [4:0] b;
    } t_cmd;

    // fold a cell number into 0..24
    function automatic logic [4:0] cell_fold(input logic [4:0] p);
        logic [4:0] q;
        q = p;
        if (q >= 5'(CELLS)) q = q - 5'(CELLS);
        return q;
    endfunction

    function automatic logic [2:0] cell_row(input logic [4:0] p);
        logic [4:0] q;
        logic [2:0] r;
        q = cell_fold(p);
        if (q >= 5'd20)      r = 3'd4;
        else if (q >= 5'd15) r = 3'd3;
        else if (q >= 5'd10) r = 3'd2;
        else if (q >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] cell_col(input logic [4:0] p);
        logic [4:0] q;
        logic [2:0] r;
        q = cell_fold(p);
        r = cell_row(p);
        return 3'(q - ({2'b00, r} << 2) - {2'b00, r});
    endfunction

    function automatic logic [4:0] cell_num(input logic [2:0] row, input logic [2:0] col);
        return ({2'b00, row} << 2) + {2'b00, row} + {2'b00, col};
    endfunction

    function automatic logic [2:0] wrap_inc(input logic [2:0] x);
        return (x == 3'(SIDE - 1)) ? 3'd0 : x + 3'd1;
    endfunction

endpackage

### src/pfde_front.sv
module pfde_front import pfde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [4:0] i_letter,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic       r_pend_v, n_pend_v;
    logic [4:0] r_pend_l, n_pend_l;
    logic [4:0] w_let;
    logic       w_acc;

    assign o_ready = !i_q_full;
    assign w_acc   = i_valid && !i_q_full;
    // fold j onto i
    assign w_let   = (i_letter == LET_J) ? LET_I : i_letter;

    always_comb begin
        n_pend_v = r_pend_v;
        n_pend_l = r_pend_l;
        o_push   = 1'b0;
        o_cmd.op = OP_CLEAR;
        o_cmd.a  = w_let;
        o_cmd.b  = LET_X;
        if (w_acc) begin
            unique case (i_action)
                ACT_NEW_KEY: begin
                    o_push   = 1'b1;
                    n_pend_v = 1'b0;
                    n_pend_l = '0;
                end
                ACT_END: begin
                    if (r_pend_v) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_PAIR;
                        o_cmd.a  = r_pend_l;
                        n_pend_v = 1'b0;
                    end
                end
                ACT_KEY: begin
                    if (i_letter < 5'(ALPHA)) begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_KEY;
                    end
                end
                default: begin
                    if (i_letter < 5'(ALPHA)) begin
                        o_push = 1'b1;
                        if (!r_pend_v) begin
                            o_cmd.op = OP_COMPLETE;
                            n_pend_v = 1'b1;
                            n_pend_l = w_let;
                        end else if (r_pend_l == w_let) begin
                            // doubled letter gets a filler, letter stays pending
                            o_cmd.op = OP_PAIR;
                            o_cmd.a  = w_let;
                            o_cmd.b  = (w_let == LET_X) ? LET_Q : LET_X;
                        end else begin
                            o_cmd.op = OP_PAIR;
                            o_cmd.a  = r_pend_l;
                            o_cmd.b  = w_let;
                            n_pend_v = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_pend_l <= '0;
        end else begin
            r_pend_v <= n_pend_v;
            r_pend_l <= n_pend_l;
        end
    end

endmodule

### src/pfde_queue.sv
module pfde_queue import pfde_pkg::*; #(
    parameter int DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (w_pop)  r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + CW'(w_push) - CW'(w_pop);
        end
    end

endmodule

### src/pfde_back.sv
module pfde_back import pfde_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_letter,
    output logic       o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_RES  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [ALPHA-1:0] r_taken, n_taken;
    logic [4:0]       r_fill, n_fill;
    logic             r_complete, n_complete;
    logic [4:0]       r_walk, n_walk;
    logic [1:0]       r_ob_cnt, n_ob_cnt;
    logic [4:0]       r_ob0, n_ob0, r_ob1, n_ob1;

    logic [4:0] mem_sq [CELLS];
    logic [4:0] mem_pl [ALPHA];
    logic [4:0] r_pa, r_pb, r_sa, r_sb;

    logic       w_we, w_app_ok;
    logic [4:0] w_app_l, w_ca, w_cb;
    logic [2:0] w_ar, w_ac, w_br, w_bc;

    assign o_valid  = (r_ob_cnt != 2'd0);
    assign o_letter = (r_ob_cnt == 2'd2) ? r_ob0 : r_ob1;
    assign o_last   = (r_ob_cnt == 2'd1);

    assign w_app_l  = (r_state == ST_WALK) ? r_walk : i_q_cmd.a;
    assign w_app_ok = !r_taken[w_app_l] && (r_fill < 5'(CELLS));

    // playfair rules on the two looked-up cells
    assign w_ar = cell_row(r_pa);
    assign w_ac = cell_col(r_pa);
    assign w_br = cell_row(r_pb);
    assign w_bc = cell_col(r_pb);

    always_comb begin
        if (w_ar == w_br) begin
            w_ca = cell_num(w_ar, wrap_inc(w_ac));
            w_cb = cell_num(w_br, wrap_inc(w_bc));
        end else if (w_ac == w_bc) begin
            w_ca = cell_num(wrap_inc(w_ar), w_ac);
            w_cb = cell_num(wrap_inc(w_br), w_bc);
        end else begin
            w_ca = cell_num(w_ar, w_bc);
            w_cb = cell_num(w_br, w_ac);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_taken    = r_taken;
        n_fill     = r_fill;
        n_complete = r_complete;
        n_walk     = r_walk;
        n_ob_cnt   = r_ob_cnt;
        n_ob0      = r_ob0;
        n_ob1      = r_ob1;
        o_q_pop    = 1'b0;
        w_we       = 1'b0;

        if (o_valid && i_ready) n_ob_cnt = r_ob_cnt - 2'd1;

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.op)
                        OP_CLEAR: begin
                            o_q_pop    = 1'b1;
                            n_taken    = '0;
                            n_fill     = '0;
                            n_complete = 1'b0;
                        end
                        OP_KEY: begin
                            o_q_pop = 1'b1;
                            w_we    = !r_complete && w_app_ok;
                        end
                        OP_COMPLETE: begin
                            if (r_complete) begin
                                o_q_pop = 1'b1;
                            end else begin
                                n_taken[LET_J] = 1'b1;
                                n_walk         = '0;
                                n_state        = ST_WALK;
                            end
                        end
                        default: begin
                            if (!r_complete) begin
                                n_taken[LET_J] = 1'b1;
                                n_walk         = '0;
                                n_state        = ST_WALK;
                            end else if (r_ob_cnt == 2'd0) begin
                                // place lookup of both letters lands next cycle
                                o_q_pop = 1'b1;
                                n_state = ST_CALC;
                            end
                        end
                    endcase
                end
            end
            ST_WALK: begin
                w_we = w_app_ok;
                if (r_walk == 5'(ALPHA - 1)) begin
                    n_complete = 1'b1;
                    n_state    = ST_IDLE;
                end else begin
                    n_walk = r_walk + 5'd1;
                end
            end
            ST_CALC: begin
                n_state = ST_RES;
            end
            default: begin
                n_ob0    = r_sa;
                n_ob1    = r_sb;
                n_ob_cnt = 2'd2;
                n_state  = ST_IDLE;
            end
        endcase

        if (w_we) begin
            n_taken[w_app_l] = 1'b1;
            n_fill           = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_sq[r_fill]  <= w_app_l;
            mem_pl[w_app_l] <= r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pa <= mem_pl[i_q_cmd.a];
        r_pb <= mem_pl[i_q_cmd.b];
        r_sa <= mem_sq[w_ca];
        r_sb <= mem_sq[w_cb];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_taken    <= '0;
            r_fill     <= '0;
            r_complete <= 1'b0;
            r_walk     <= '0;
            r_ob_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_taken    <= n_taken;
            r_fill     <= n_fill;
            r_complete <= n_complete;
            r_walk     <= n_walk;
            r_ob_cnt   <= n_ob_cnt;
        end
        r_ob0 <= n_ob0;
        r_ob1 <= n_ob1;
    end

    a_res_into_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RES |-> r_ob_cnt == 2'd0)
        else $error("result pair lands on an occupied output buffer");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= 5'(CELLS))
        else $error("square fill count overran");

    a_walk_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WALK && r_walk == 5'(ALPHA - 1) |=> r_complete && r_state == ST_IDLE)
        else $error("square walk did not finish");

    a_full_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_complete |-> r_fill == 5'(CELLS))
        else $error("square marked complete with empty cells");

endmodule

### src/playfair_digraph_encryptor.sv
// channel | dir | handshake            | tdata                  | side band
// s       | in  | i_s_tvalid/o_s_tready | [4:0] letter, [7:5] 0  | tuser [1:0] action
// m       | out | o_m_tvalid/i_m_tready | [4:0] cipher_letter    | tlast last_of_pair
//
// the front takes one word per cycle while the command queue has room
// a pair runs idle, calc and result, then two output beats; key or clear, idle only
// the first message letter after a new key walks all 26 letters, once per key
// reset is synchronous, active low, and clears the square bookkeeping and pending letter
// a stalled output only holds the back end on the next pair; the front keeps queueing
module playfair_digraph_encryptor import pfde_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [4:0] letter, [7:5] zero
    input  logic [1:0] i_s_tuser,   // [1:0] action
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [4:0] cipher_letter, [7:5] zero
    output logic       o_m_tlast    // last_of_pair
);

    // front to queue
    logic w_push, w_q_full;
    t_cmd w_push_cmd;

    // queue to back
    logic w_q_valid, w_q_pop;
    t_cmd w_q_cmd;

    logic [4:0] w_cipher;

    // classify words, keep pairing state, build commands
    pfde_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_action (i_s_tuser),
        .i_letter (i_s_tdata[4:0]),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_cmd    (w_push_cmd)
    );

    // short command queue decouples the two halves
    pfde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // square build, lookup and two-word result buffer
    pfde_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_cmd   (w_q_cmd),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_letter  (w_cipher),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {3'b000, w_cipher};

endmodule

### test/testbench.sv
module testbench;
    import pfde_pkg::*;

    // one expected output word: cipher letter and its place in the digraph
    typedef struct packed {
        logic [4:0] ch;
        logic       last;
    } t_cipher_word;

    // one row of the directed table; want_a/want_b are used only where typed is set
    typedef struct packed {
        logic [1:0] act;
        logic [4:0] ch;
        logic       typed;
        logic [4:0] want_a;
        logic [4:0] want_b;
    } t_demo_word;

    localparam int DEMO_ROWS   = 29;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 64;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata  = 8'd0;   // [4:0] letter, [7:5] zero
    logic [1:0] i_s_tuser  = ACT_NEW_KEY;   // [1:0] action
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [4:0] cipher_letter, [7:5] zero
    logic       o_m_tlast;           // last_of_pair

    // travels with the driven word so the watcher knows a typed expectation
    logic       word_typed  = 1'b0;
    logic [4:0] word_want_a = 5'd0;
    logic [4:0] word_want_b = 5'd0;

    int  idle_pct       = 0;
    int  stall_pct      = 0;
    bit  hold_go        = 1'b0;
    int  items_sent     = 0;
    int  mismatch_count = 0;

    t_cipher_word cipher_expected [$];
    t_demo_word   demo_words [DEMO_ROWS];

    // square kept by the predictor
    logic       sq_taken [ALPHA];
    logic [4:0] sq_cell  [CELLS];
    logic [4:0] sq_place [ALPHA];
    int         sq_fill;
    bit         sq_done;
    bit         lone_valid;
    logic [4:0] lone_letter;

    playfair_digraph_encryptor DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #400000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    function automatic void square_clear();
        for (int i = 0; i < ALPHA; i++) sq_taken[i] = 1'b0;
        sq_fill     = 0;
        sq_done     = 1'b0;
        lone_valid  = 1'b0;
        lone_letter = 5'd0;
    endfunction

    function automatic void square_append(input logic [4:0] c);
        if (c >= ALPHA || sq_taken[c] || sq_fill >= CELLS) return;
        sq_taken[c]      = 1'b1;
        sq_cell[sq_fill] = c;
        sq_place[c]      = 5'(sq_fill);
        sq_fill++;
    endfunction

    // fill the rest of the square alphabetically, J left out
    function automatic void square_finish();
        if (sq_done) return;
        sq_taken[LET_J] = 1'b1;
        for (int c = 0; c < ALPHA; c++) square_append(5'(c));
        sq_done = 1'b1;
    endfunction

    function automatic void digraph_encrypt(input logic [4:0] a, input logic [4:0] b,
                                            output logic [4:0] ca, output logic [4:0] cb);
        int pa, pb, ar, ac, br, bc;
        pa = sq_place[a];
        pb = sq_place[b];
        ar = pa / SIDE;
        ac = pa % SIDE;
        br = pb / SIDE;
        bc = pb % SIDE;
        if (ar == br) begin
            ca = sq_cell[ar * SIDE + (ac + 1) % SIDE];
            cb = sq_cell[br * SIDE + (bc + 1) % SIDE];
        end else if (ac == bc) begin
            ca = sq_cell[((ar + 1) % SIDE) * SIDE + ac];
            cb = sq_cell[((br + 1) % SIDE) * SIDE + bc];
        end else begin
            ca = sq_cell[ar * SIDE + bc];
            cb = sq_cell[br * SIDE + ac];
        end
    endfunction

    // advance the predicted square by one accepted word; n is 0 or 2 cipher words
    function automatic void playfair_predict(input logic [1:0] act, input logic [4:0] ch_in,
                                             output int n, output logic [4:0] c0,
                                             output logic [4:0] c1);
        logic [4:0] ch;
        ch = ch_in;
        n  = 0;
        c0 = 5'd0;
        c1 = 5'd0;
        case (act)
            ACT_NEW_KEY: begin
                square_clear();
            end
            ACT_END: begin
                if (lone_valid) begin
                    square_finish();
                    digraph_encrypt(lone_letter, LET_X, c0, c1);
                    lone_valid = 1'b0;
                    n = 2;
                end
            end
            default: begin
                if (ch < ALPHA) begin
                    if (ch == LET_J) ch = LET_I;
                    if (act == ACT_KEY) begin
                        if (!sq_done) square_append(ch);
                    end else begin
                        square_finish();
                        if (!lone_valid) begin
                            lone_letter = ch;
                            lone_valid  = 1'b1;
                        end else if (lone_letter == ch) begin
                            // doubled letter: pair with filler, letter stays pending
                            digraph_encrypt(lone_letter, (ch == LET_X) ? LET_Q : LET_X, c0, c1);
                            n = 2;
                        end else begin
                            digraph_encrypt(lone_letter, ch, c0, c1);
                            lone_valid = 1'b0;
                            n = 2;
                        end
                    end
                end
            end
        endcase
    endfunction

    // checks output words first, then predicts from the input word of the same edge
    always @(posedge i_clk) begin : watch
        int           pair_count;
        logic [4:0]   first_c, second_c;
        t_cipher_word want;
        t_cipher_word word_a, word_b;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (cipher_expected.size() == 0) begin
                    report_mismatch("word with nothing expected", o_m_tdata, 0);
                end else begin
                    want = cipher_expected.pop_front();
                    if (o_m_tdata !== {3'b000, want.ch})
                        report_mismatch("cipher letter", o_m_tdata, want.ch);
                    if (o_m_tlast !== want.last)
                        report_mismatch("last of pair", o_m_tlast, want.last);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                playfair_predict(i_s_tuser, i_s_tdata[4:0], pair_count, first_c, second_c);
                if (word_typed) begin
                    first_c  = word_want_a;
                    second_c = word_want_b;
                end
                if (word_typed || pair_count == 2) begin
                    word_a.ch       = first_c;
                    word_a.last     = 1'b0;
                    word_b.ch       = second_c;
                    word_b.last     = 1'b1;
                    cipher_expected = {cipher_expected, word_a, word_b};
                end
            end
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // offer one word and return at the edge that takes it; valid stays high
    task automatic send_word(input logic [1:0] act, input logic [4:0] ch, input logic typed,
                             input logic [4:0] wa, input logic [4:0] wb);
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid  <= 1'b1;
        i_s_tuser   <= act;
        i_s_tdata   <= {3'b000, ch};
        word_typed  <= typed;
        word_want_a <= wa;
        word_want_b <= wb;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // stop sending and wait for every cipher word, then let the back end settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (cipher_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic logic [4:0] pick_letter();
        if ($urandom_range(11) == 0) return 5'($urandom_range(31, 26));
        return 5'($urandom_range(25));
    endfunction

    // mostly a well-formed key then message, sometimes plain noise
    task automatic send_session();
        int         key_len, msg_len;
        logic [4:0] ch, prev;
        prev = pick_letter();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(6, 1))
                send_word(2'($urandom_range(3)), 5'($urandom_range(31)), 1'b0, 5'd0, 5'd0);
        end else begin
            if ($urandom_range(3) != 0) begin
                send_word(ACT_NEW_KEY, 5'($urandom_range(31)), 1'b0, 5'd0, 5'd0);
                key_len = ($urandom_range(7) == 0) ? 30 : $urandom_range(10);
                repeat (key_len) send_word(ACT_KEY, pick_letter(), 1'b0, 5'd0, 5'd0);
            end
            msg_len = $urandom_range(12, 1);
            repeat (msg_len) begin
                if ($urandom_range(4) == 0)      ch = prev;
                else if ($urandom_range(9) == 0) ch = LET_X;
                else                             ch = pick_letter();
                send_word(ACT_MSG, ch, 1'b0, 5'd0, 5'd0);
                prev = ch;
            end
            if ($urandom_range(7) != 0)
                send_word(ACT_END, 5'($urandom_range(31)), 1'b0, 5'd0, 5'd0);
        end
    endtask

    task automatic random_phase(input int sender_idle, input int receiver_stall,
                                input int count);
        int target;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = items_sent + count;
        while (items_sent < target) send_session();
        drain();
    endtask

    initial begin
        square_clear();
        // empty key gives the plain alphabet square:
        // A B C D E / F G H I K / L M N O P / Q R S T U / V W X Y Z
        demo_words = '{
            '{ACT_MSG,     5'd0,  1'b0, 5'd0,  5'd0 },   // A
            '{ACT_MSG,     5'd1,  1'b1, 5'd1,  5'd2 },   // B: same row
            '{ACT_MSG,     5'd0,  1'b0, 5'd0,  5'd0 },   // A
            '{ACT_MSG,     5'd5,  1'b1, 5'd5,  5'd11},   // F: same column
            '{ACT_MSG,     5'd0,  1'b0, 5'd0,  5'd0 },   // A
            '{ACT_MSG,     5'd6,  1'b1, 5'd1,  5'd5 },   // G: rectangle
            '{ACT_MSG,     5'd25, 1'b0, 5'd0,  5'd0 },   // Z
            '{ACT_END,     5'd0,  1'b1, 5'd21, 5'd24},   // lone Z padded with X
            '{ACT_END,     5'd31, 1'b0, 5'd0,  5'd0 },   // nothing pending
            '{ACT_MSG,     LET_X, 1'b0, 5'd0,  5'd0 },
            '{ACT_END,     5'd0,  1'b1, 5'd24, 5'd24},   // trailing X padded with X
            '{ACT_MSG,     LET_X, 1'b0, 5'd0,  5'd0 },
            '{ACT_MSG,     LET_X, 1'b1, 5'd21, 5'd18},   // doubled X takes Q
            '{ACT_END,     5'd0,  1'b1, 5'd24, 5'd24},
            '{ACT_MSG,     LET_J, 1'b0, 5'd0,  5'd0 },   // J folds onto I
            '{ACT_MSG,     5'd31, 1'b0, 5'd0,  5'd0 },   // out of range, ignored
            '{ACT_MSG,     5'd10, 1'b1, 5'd10, 5'd5 },   // K
            '{ACT_MSG,     5'd1,  1'b0, 5'd0,  5'd0 },   // B
            '{ACT_MSG,     5'd1,  1'b1, 5'd2,  5'd22},   // doubled B takes X
            '{ACT_NEW_KEY, 5'd31, 1'b0, 5'd0,  5'd0 },   // drops the pending B
            '{ACT_KEY,     5'd25, 1'b0, 5'd0,  5'd0 },   // Z
            '{ACT_KEY,     LET_J, 1'b0, 5'd0,  5'd0 },
            '{ACT_KEY,     5'd25, 1'b0, 5'd0,  5'd0 },   // repeated, ignored
            '{ACT_KEY,     5'd26, 1'b0, 5'd0,  5'd0 },   // out of range, ignored
            '{ACT_KEY,     5'd0,  1'b0, 5'd0,  5'd0 },   // A
            '{ACT_MSG,     LET_I, 1'b0, 5'd0,  5'd0 },
            '{ACT_MSG,     5'd0,  1'b0, 5'd0,  5'd0 },
            '{ACT_KEY,     5'd2,  1'b0, 5'd0,  5'd0 },   // square complete, ignored
            '{ACT_MSG,     5'd3,  1'b0, 5'd0,  5'd0 }
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DEMO_ROWS; r++)
            send_word(demo_words[r].act, demo_words[r].ch, demo_words[r].typed,
                      demo_words[r].want_a, demo_words[r].want_b);
        send_word(ACT_END, 5'd0, 1'b0, 5'd0, 5'd0);
        drain();

        random_phase(0, 0, 110);
        random_phase(82, 0, 110);
        random_phase(0, 82, 110);

        // receiver holds off while message letters keep coming, filling the block
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b1;
        repeat (30) send_word(ACT_MSG, pick_letter(), 1'b0, 5'd0, 5'd0);
        drain();

        random_phase(33, 33, 110);

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
src/pfde_pkg.sv
src/pfde_front.sv
src/pfde_queue.sv
src/pfde_back.sv
src/playfair_digraph_encryptor.sv
test/testbench.sv
